// File: design/urx_pkg.sv
// Package for the framed UART receiver: register indexes, widths,
// configuration struct and receiver phase encoding.
// No dependencies.
package urx_pkg;

  // Configuration port widths
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 16;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_BIT_TICKS   = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_DATA_BITS   = 4'd1;
  localparam logic [CfgIdxW-1:0] CFG_PARITY_MODE = 4'd2;
  localparam logic [CfgIdxW-1:0] CFG_EXTRA_STOP  = 4'd3;

  // Parity mode codes (parity bit is skipped, never checked)
  localparam logic [1:0] PAR_NONE = 2'd0;
  localparam logic [1:0] PAR_O    = 2'd1;
  localparam logic [1:0] PAR_E    = 2'd2;

  // Reset values of the configuration registers
  localparam logic [15:0] BIT_TICKS_RST = 16'd104;
  localparam logic [3:0]  DATA_BITS_RST = 4'd8;

  // Data bit count limits
  localparam logic [3:0] DATA_BITS_MIN = 4'd5;
  localparam logic [3:0] DATA_BITS_MAX = 4'd8;

  // Live configuration handed to the framing core
  typedef struct packed {
    logic [15:0] bit_ticks;
    logic [3:0]  data_bits;
    logic [1:0]  parity_mode;
    logic        extra_stop;
  } urx_cfg_t;

  // Receiver phase, one-hot
  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_START  = 6'b000010,
    PH_DATA   = 6'b000100,
    PH_PARITY = 6'b001000,
    PH_STOP1  = 6'b010000,
    PH_STOP2  = 6'b100000
  } urx_phase_t;

endpackage

// File: design/urx_if.sv
// Channel interfaces of the framed UART receiver: sample ticks in,
// characters out, and the configuration write channel.
// Depends on urx_pkg.
interface urx_in_if;
  logic valid;
  logic ready;
  logic rx_level;

  modport source (output valid, output rx_level, input ready);
  modport sink   (input valid, input rx_level, output ready);
endinterface

interface urx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_data;

  modport source (output valid, output char_data, input ready);
  modport sink   (input valid, input char_data, output ready);
endinterface

interface urx_cfg_if
  import urx_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/urx_core.sv
// Framing state machine of the UART receiver: start detect, mid-bit data
// sampling, parity skip and stop bits. Advances one tick per accepted beat.
// Depends on urx_pkg.
module urx_core
  import urx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       tick_en,
  input  logic       rx_level,
  input  urx_cfg_t   cfg,
  output logic       char_valid,
  output logic [7:0] char_data
);

  urx_phase_t  phase_r, phase_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [7:0]  shift_r, shift_nxt;

  logic [15:0] period;
  logic [15:0] half;
  logic [3:0]  eff_bits;
  logic [3:0]  idx_inc;
  logic        has_parity;
  logic        tick_more;

  // Effective configuration: zero period acts as one, data bits clamped
  always_comb begin
    period = (cfg.bit_ticks == 16'd0) ? 16'd1 : cfg.bit_ticks;
    half   = {1'b0, period[15:1]};
    if (cfg.data_bits < DATA_BITS_MIN) begin
      eff_bits = DATA_BITS_MIN;
    end else if (cfg.data_bits > DATA_BITS_MAX) begin
      eff_bits = DATA_BITS_MAX;
    end else begin
      eff_bits = cfg.data_bits;
    end
    has_parity = (cfg.parity_mode != PAR_NONE);
    idx_inc    = {1'b0, idx_r} + 4'd1;
    tick_more  = |tick_r[15:1];
  end

  // Next state for one tick
  always_comb begin
    phase_nxt  = phase_r;
    tick_nxt   = tick_r;
    idx_nxt    = idx_r;
    shift_nxt  = shift_r;
    char_valid = 1'b0;
    if (tick_en) begin
      if (phase_r == PH_IDLE) begin
        // wait for the start edge
        if (!rx_level) begin
          shift_nxt = 8'd0;
          idx_nxt   = 3'd0;
          if (half == 16'd0) begin
            phase_nxt = PH_DATA;
            tick_nxt  = period;
          end else begin
            phase_nxt = PH_START;
            tick_nxt  = half;
          end
        end
      end else if (tick_more) begin
        tick_nxt = tick_r - 16'd1;
      end else begin
        tick_nxt = period;
        unique case (phase_r)
          PH_START: begin
            phase_nxt = PH_DATA;
            idx_nxt   = 3'd0;
            shift_nxt = 8'd0;
          end
          PH_DATA: begin
            shift_nxt = shift_r | (8'(rx_level) << idx_r);
            if (idx_inc >= eff_bits) begin
              idx_nxt   = 3'd0;
              phase_nxt = has_parity ? PH_PARITY : PH_STOP1;
            end else begin
              idx_nxt = idx_inc[2:0];
            end
          end
          PH_PARITY: begin
            phase_nxt = PH_STOP1;
          end
          PH_STOP1: begin
            if (cfg.extra_stop) begin
              phase_nxt = PH_STOP2;
            end else begin
              char_valid = 1'b1;
              phase_nxt  = PH_IDLE;
              tick_nxt   = 16'd0;
              idx_nxt    = 3'd0;
            end
          end
          PH_STOP2: begin
            char_valid = 1'b1;
            phase_nxt  = PH_IDLE;
            tick_nxt   = 16'd0;
            idx_nxt    = 3'd0;
          end
          default: begin
            phase_nxt = PH_IDLE;
            tick_nxt  = 16'd0;
          end
        endcase
      end
    end
  end

  assign char_data = shift_r;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= 16'd0;
      idx_r   <= 3'd0;
      shift_r <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      idx_r   <= idx_nxt;
      shift_r <= shift_nxt;
    end
  end

endmodule

// File: design/uart_receiver_framed.sv
// Top level of the framed UART receiver: configuration registers, the
// framing core and the character output register.
// Depends on urx_pkg, urx_if.sv and urx_core.
//
//  channel  dir  payload                 beat
//  in_bus   in   rx_level (1)            one line sample tick
//  out_bus  out  char_data (8)           one received character
//  cfg_bus  in   index (4), data (16)    one register write
//
// A tick beat is taken every cycle while in_bus.ready is high; each tick is
// worked in the cycle it is accepted and a finished character appears in
// the output register on the next cycle. in_bus.ready drops only while a
// character waits in the output register and out_bus.ready is low. Reset
// (rst_n, synchronous) returns the receiver to idle and the registers to
// 104 ticks, 8 data bits, no parity, one stop bit. cfg_bus is always ready.
module uart_receiver_framed
  import urx_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  urx_in_if.sink    in_bus,
  urx_out_if.source out_bus,
  urx_cfg_if.sink   cfg_bus
);

  urx_cfg_t   cfg_r;
  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic       tick_en;
  logic       char_valid;
  logic [7:0] char_data;

  assign in_bus.ready  = !out_valid_r || out_bus.ready;
  assign tick_en       = in_bus.valid && in_bus.ready;
  assign cfg_bus.ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_ticks   <= BIT_TICKS_RST;
      cfg_r.data_bits   <= DATA_BITS_RST;
      cfg_r.parity_mode <= PAR_NONE;
      cfg_r.extra_stop  <= 1'b0;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        CFG_BIT_TICKS:   cfg_r.bit_ticks   <= cfg_bus.data;
        CFG_DATA_BITS:   cfg_r.data_bits   <= cfg_bus.data[3:0];
        CFG_PARITY_MODE: cfg_r.parity_mode <= cfg_bus.data[1:0];
        CFG_EXTRA_STOP:  cfg_r.extra_stop  <= cfg_bus.data[0];
        default: ;
      endcase
    end
  end

  urx_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_en    (tick_en),
    .rx_level   (in_bus.rx_level),
    .cfg        (cfg_r),
    .char_valid (char_valid),
    .char_data  (char_data)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (char_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid) begin
      out_data_r <= char_data;
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.char_data = out_data_r;

endmodule

// File: tb/tb_uart_receiver_framed.sv
// Testbench for uart_receiver_framed: drives line-sample ticks and register writes,
// predicts received characters and checks every output beat against the prediction.
// Depends on urx_pkg, design/urx_if.sv and the receiver RTL.
`timescale 1ns / 100ps

module tb_uart_receiver_framed;
  import urx_pkg::*;

  // Parity code with no name in the package; still means "skip one parity bit"
  localparam logic [1:0] PAR_ODD_CODE3 = 2'd3;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE_CYCLES = 4;

  // Character predictor and expected-character store
  class char_scoreboard;
    logic [15:0] bit_ticks;
    logic [3:0]  data_bits;
    logic [1:0]  parity_mode;
    logic        extra_stop;
    urx_phase_t  phase;
    logic [15:0] tick_left;
    logic [2:0]  bit_pos;
    logic [7:0]  shift_char;
    logic [7:0]  expected_chars[$];
    int unsigned live_ticks;
    int unsigned chars_made;
    int unsigned chars_ok;
    int unsigned mismatches;

    function new();
      bit_ticks   = BIT_TICKS_RST;
      data_bits   = DATA_BITS_RST;
      parity_mode = PAR_NONE;
      extra_stop  = 1'b0;
      phase       = PH_IDLE;
      tick_left   = '0;
      bit_pos     = '0;
      shift_char  = '0;
      live_ticks  = 0;
      chars_made  = 0;
      chars_ok    = 0;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_BIT_TICKS:   bit_ticks = val;
        CFG_DATA_BITS:   data_bits = val[3:0];
        CFG_PARITY_MODE: parity_mode = val[1:0];
        CFG_EXTRA_STOP:  extra_stop = val[0];
        default: ;
      endcase
    endfunction

    // Advance the framing state by one accepted tick
    function void take_tick(logic lvl);
      logic [15:0] per;
      int          nbits;
      bit          done;
      per = (bit_ticks == 16'd0) ? 16'd1 : bit_ticks;
      nbits = int'(data_bits);
      if (nbits < int'(DATA_BITS_MIN)) nbits = int'(DATA_BITS_MIN);
      if (nbits > int'(DATA_BITS_MAX)) nbits = int'(DATA_BITS_MAX);
      done = 1'b0;
      if (phase == PH_IDLE) begin
        // start edge: first low tick while idle, no recheck later
        if (!lvl) begin
          live_ticks++;
          shift_char = '0;
          bit_pos = '0;
          if ((per >> 1) == 16'd0) begin
            phase = PH_DATA;
            tick_left = per;
          end else begin
            phase = PH_START;
            tick_left = per >> 1;
          end
        end
      end else begin
        live_ticks++;
        if (tick_left > 16'd1) begin
          tick_left--;
        end else begin
          tick_left = per;
          case (phase)
            PH_START: begin
              phase = PH_DATA;
              bit_pos = '0;
              shift_char = '0;
            end
            PH_DATA: begin
              shift_char[bit_pos] = lvl;
              if (int'(bit_pos) + 1 >= nbits) begin
                bit_pos = '0;
                phase = (parity_mode != PAR_NONE) ? PH_PARITY : PH_STOP1;
              end else begin
                bit_pos++;
              end
            end
            PH_PARITY: phase = PH_STOP1;
            PH_STOP1: begin
              if (extra_stop) phase = PH_STOP2;
              else done = 1'b1;
            end
            PH_STOP2: done = 1'b1;
            default: begin
              phase = PH_IDLE;
              tick_left = '0;
            end
          endcase
        end
      end
      // character emitted at mid of the last stop bit
      if (done) begin
        expected_chars.push_back(shift_char);
        chars_made++;
        phase = PH_IDLE;
        tick_left = '0;
        bit_pos = '0;
      end
    endfunction

    function void check_char(logic [7:0] got);
      logic [7:0] want;
      if (expected_chars.size() == 0) begin
        mismatches++;
        $display("%0t: char_data expected none actual %h", $time, got);
      end else begin
        want = expected_chars.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: char_data expected %h actual %h", $time, want, got);
        end else begin
          chars_ok++;
        end
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  urx_in_if  in_bus();
  urx_out_if out_bus();
  urx_cfg_if cfg_bus();

  uart_receiver_framed dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  char_scoreboard sb;

  // Line settings used by the frame generator
  int tx_period;
  int tx_bits;
  bit tx_parity;
  int tx_stops;

  int in_idle_pct;
  int out_stall_pct;
  int unsigned cycles = 0;
  int unsigned n_configs;

  // Clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d characters outstanding", $time, sb.pending());
      $display("FAIL uart_receiver_framed");
      $finish;
    end
  end

  // Result side: random stall, check each accepted beat
  always @(posedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) sb.check_char(out_bus.char_data);
  end

  // One tick beat, with random sender gaps ahead of it
  task automatic send_tick(input logic lvl);
    while ($urandom_range(99) < in_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.rx_level <= lvl;
    do @(posedge clk); while (!in_bus.ready);
    sb.take_tick(lvl);
  endtask

  task automatic send_level(input logic lvl, input int n);
    repeat (n) send_tick(lvl);
  endtask

  // Bit length; jittered for broken frames
  function automatic int bit_len(bit broken);
    int d;
    int n;
    if (!broken) return tx_period;
    d = tx_period / 4 + 1;
    n = tx_period + int'($urandom_range(0, 2 * d)) - d;
    return (n < 1) ? 1 : n;
  endfunction

  task automatic send_frame(input logic [7:0] ch, input bit broken);
    int i;
    int gap;
    send_level(1'b0, bit_len(broken));
    for (i = 0; i < tx_bits; i++) send_level(ch[i], bit_len(broken));
    if (tx_parity) send_level(1'($urandom_range(1)), bit_len(broken));
    for (i = 0; i < tx_stops; i++) begin
      send_level(broken ? 1'($urandom_range(1)) : 1'b1, bit_len(broken));
    end
    gap = (tx_period <= 64) ? $urandom_range(0, 3 * tx_period) : $urandom_range(0, 16);
    send_level(1'b1, gap);
  endtask

  // Finish any frame in flight, then hold the sender until all characters are back
  task automatic quiesce();
    while (sb.phase != PH_IDLE) send_tick(1'b1);
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    sb.write_reg(idx, val);
  endtask

  // Writes all four registers; block must be idle
  task automatic load_config(input logic [15:0] ticks, input logic [3:0] nbits,
                             input logic [1:0] pmode, input logic two_stop);
    write_reg(CFG_BIT_TICKS, ticks);
    write_reg(CFG_DATA_BITS, {12'd0, nbits});
    write_reg(CFG_PARITY_MODE, {14'd0, pmode});
    write_reg(CFG_EXTRA_STOP, {15'd0, two_stop});
    cfg_bus.valid <= 1'b0;
    tx_period = (ticks == 16'd0) ? 1 : int'(ticks);
    tx_bits = int'(nbits);
    if (tx_bits < int'(DATA_BITS_MIN)) tx_bits = int'(DATA_BITS_MIN);
    if (tx_bits > int'(DATA_BITS_MAX)) tx_bits = int'(DATA_BITS_MAX);
    tx_parity = (pmode != PAR_NONE);
    tx_stops = two_stop ? 2 : 1;
    n_configs++;
  endtask

  initial begin
    int ph;
    int frames;
    int kind;
    int len;
    int unsigned start_live;
    int unsigned start_made;
    logic [15:0] ticks;
    logic [3:0] nbits;

    sb = new();
    rst_n <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.rx_level <= 1'b1;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= CFG_BIT_TICKS;
    cfg_bus.data <= '0;
    tx_period = int'(BIT_TICKS_RST);
    tx_bits = int'(DATA_BITS_RST);
    tx_parity = 1'b0;
    tx_stops = 1;
    in_idle_pct = 0;
    out_stall_pct = 0;
    n_configs = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset framing settings (8 data bits, no parity, one stop), short bit
    write_reg(CFG_BIT_TICKS, 16'd3);
    cfg_bus.valid <= 1'b0;
    tx_period = 3;
    send_frame(8'hA5, 1'b0);
    quiesce();
    // one-tick bit, half period of zero
    load_config(16'd1, 4'd8, PAR_NONE, 1'b0);
    send_frame(8'h00, 1'b0);
    send_frame(8'hFF, 1'b0);
    send_frame(8'h55, 1'b0);
    quiesce();
    // zero bit period acts as one
    load_config(16'd0, 4'd8, PAR_O, 1'b1);
    send_frame(8'h3C, 1'b0);
    quiesce();
    load_config(16'd2, 4'd5, PAR_O, 1'b1);
    send_frame(8'h1F, 1'b0);
    send_frame(8'h0A, 1'b0);
    quiesce();
    // data bit count below range acts as five
    load_config(16'd3, 4'd0, PAR_E, 1'b0);
    send_frame(8'h15, 1'b0);
    quiesce();
    // above range acts as eight; parity code three still skips a bit
    load_config(16'd3, 4'd15, PAR_ODD_CODE3, 1'b1);
    send_frame(8'hC3, 1'b0);
    quiesce();
    load_config(16'd4, 4'd6, PAR_NONE, 1'b0);
    send_frame(8'h2A, 1'b0);
    quiesce();
    load_config(16'd5, 4'd7, PAR_E, 1'b1);
    send_frame(8'h6B, 1'b0);
    quiesce();
    // single-tick glitch still starts a frame
    load_config(16'd2, 4'd8, PAR_NONE, 1'b0);
    send_tick(1'b0);
    send_level(1'b1, 40);
    quiesce();

    // Random frames under four idling modes
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 87; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 87; end
        default: begin in_idle_pct = 18; out_stall_pct = 18; end
      endcase
      start_live = sb.live_ticks;
      start_made = sb.chars_made;
      frames = 0;
      while (sb.live_ticks - start_live < 120 || sb.chars_made - start_made < 4) begin
        if (frames % 3 == 0) begin
          quiesce();
          ticks = ($urandom_range(9) == 0) ? 16'($urandom_range(7, 40))
                                           : 16'($urandom_range(0, 6));
          nbits = ($urandom_range(4) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(5, 8));
          load_config(ticks, nbits, 2'($urandom_range(3)), 1'($urandom_range(1)));
        end else if (frames % 3 == 2 && $urandom_range(1) == 0) begin
          quiesce();
        end
        kind = $urandom_range(99);
        if (kind < 75) begin
          send_frame(8'($urandom), 1'b0);
        end else if (kind < 90) begin
          send_frame(8'($urandom), 1'b1);
        end else begin
          // noise burst of random levels
          len = (8 * tx_period > 64) ? 64 : 8 * tx_period;
          len = $urandom_range(1, len);
          repeat (len) send_tick(1'($urandom_range(1)));
        end
        frames++;
      end
    end

    quiesce();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d frame-relevant ticks and %0d checked characters",
             sb.live_ticks, sb.chars_ok);
    $display("over %0d register settings and four sender/receiver idling modes", n_configs);
    if (sb.mismatches == 0) begin
      $display("PASS uart_receiver_framed");
    end else begin
      $display("FAIL uart_receiver_framed");
    end
    $finish;
  end

endmodule

// File: uart_receiver_framed.f
design/urx_pkg.sv
design/urx_if.sv
design/urx_core.sv
design/uart_receiver_framed.sv
tb/tb_uart_receiver_framed.sv
